[rtl/thermocouple_plausibility_filter_macros.svh]
// ----------------------------------------------------------------------------
// Thermocouple plausibility filter assertion macros
// Implication checks used by the filter modules; empty outside simulation.
// ----------------------------------------------------------------------------
`ifndef THERMOCOUPLE_PLAUSIBILITY_FILTER_MACROS_SVH
`define THERMOCOUPLE_PLAUSIBILITY_FILTER_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define TPF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tpf: same-cycle check failed");
// next-cycle implication
`define TPF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tpf: next-cycle check failed");
`else
`define TPF_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define TPF_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

[rtl/tpf_pkg.sv]
// ----------------------------------------------------------------------------
// Thermocouple plausibility filter package
// Shared types, register indexes and reset values of the filter.
// ----------------------------------------------------------------------------
package tpf_pkg;

    localparam int unsigned CfgIdxW  = 3;
    localparam int unsigned CfgDataW = 16;
    localparam int unsigned InDataW  = 16;
    localparam int unsigned InUserW  = 2;
    localparam int unsigned OutDataW = 24;

    // register indexes
    typedef enum logic [CfgIdxW-1:0] {
        REG_READ_INTERVAL   = 3'd0,
        REG_LOW_LIMIT       = 3'd1,
        REG_HIGH_LIMIT      = 3'd2,
        REG_MAX_DROP        = 3'd3,
        REG_MAX_RISE        = 3'd4,
        REG_ERROR_LIMIT     = 3'd5,
        REG_CLICK_THRESHOLD = 3'd6
    } t_reg_idx;

    // register reset values
    localparam logic        [15:0] RST_READ_INTERVAL   = 16'd250;
    localparam logic signed [12:0] RST_LOW_LIMIT       = -13'sd80;
    localparam logic signed [12:0] RST_HIGH_LIMIT      = 13'sd920;
    localparam logic        [11:0] RST_MAX_DROP        = 12'd32;
    localparam logic        [11:0] RST_MAX_RISE        = 12'd200;
    localparam logic        [7:0]  RST_ERROR_LIMIT     = 8'd5;
    localparam logic signed [12:0] RST_CLICK_THRESHOLD = 13'sd760;

    localparam logic [15:0] TICKS_MAX = 16'hFFFF;
    localparam logic [7:0]  COUNT_MAX = 8'hFF;

    typedef struct packed {
        logic        [15:0] read_interval;
        logic signed [12:0] low_limit;
        logic signed [12:0] high_limit;
        logic        [11:0] max_drop;
        logic        [11:0] max_rise;
        logic        [7:0]  error_limit;
        logic signed [12:0] click_threshold;
    } t_cfg;

    typedef struct packed {
        logic        action;
        logic [11:0] reading;
        logic        open_fault;
    } t_item;

    typedef struct packed {
        logic        click_event;
        logic [7:0]  fail_count;
        logic        temp_valid;
        logic [11:0] temperature;
        logic        accepted;
        logic        sampled;
    } t_result;

endpackage

[rtl/thermocouple_plausibility_filter.sv]
// Path: an accepted word passes the input register, then the result
// register. Throughput: one word per cycle while the master side takes
// results; the state update is a single pass of compares, one subtraction,
// a negation and saturating increments between the two registers.
// Reset: synchronous, active low; clears the filter state, both stage valids
// and loads the register defaults. No clearing pass is needed.
// ----------------------------------------------------------------------------
// Thermocouple plausibility filter
// Tick stream in, one filtered status word out per tick.
// ----------------------------------------------------------------------------
`include "thermocouple_plausibility_filter_macros.svh"

module thermocouple_plausibility_filter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // slave side
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [tpf_pkg::InDataW-1:0]   i_s_tdata,   // [11:0] reading, [15:12] zero
    input  logic [tpf_pkg::InUserW-1:0]   i_s_tuser,   // [0] action, [1] open_fault
    // master side
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [tpf_pkg::OutDataW-1:0]  o_m_tdata,   // [0] sampled, [1] accepted,
                                                        // [13:2] temperature,
                                                        // [14] temp_valid,
                                                        // [22:15] fail_count,
                                                        // [23] click_event
    // configuration write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [tpf_pkg::CfgIdxW-1:0]   i_cfg_index,
    input  logic [tpf_pkg::CfgDataW-1:0]  i_cfg_data
);
    import tpf_pkg::*;

    t_cfg    cfg;
    t_item   r_in;
    logic    r_in_valid;
    t_result r_out;
    logic    r_out_valid;
    t_result result;
    logic    advance;

    tpf_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // move a word from the input register to the result register
    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;

    tpf_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_advance(advance),
        .i_item   (r_in),
        .i_cfg    (cfg),
        .o_result (result)
    );

    // input register: load on accept
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in.action     <= i_s_tuser[0];
            r_in.reading    <= i_s_tdata[11:0];
            r_in.open_fault <= i_s_tuser[1];
        end
    end

    // result register: hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out;

    `TPF_ASSERT_IMP(a_stall_cause, i_clk, i_rst_n, !o_s_tready,
                    r_in_valid && r_out_valid && !i_m_tready)
    `TPF_ASSERT_NXT(a_advance_fills, i_clk, i_rst_n, advance, r_out_valid)

endmodule

[rtl/tpf_cfg.sv]
// ----------------------------------------------------------------------------
// Thermocouple plausibility filter configuration registers
// Decodes the write channel into the filter's limit and timing registers.
// ----------------------------------------------------------------------------
module tpf_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [tpf_pkg::CfgIdxW-1:0]   i_cfg_index,
    input  logic [tpf_pkg::CfgDataW-1:0]  i_cfg_data,
    output tpf_pkg::t_cfg                 o_cfg
);
    import tpf_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    // writes never stall
    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // decode the register index; unknown indexes drop the word
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_READ_INTERVAL:   n_cfg.read_interval   = i_cfg_data;
                REG_LOW_LIMIT:       n_cfg.low_limit       = i_cfg_data[12:0];
                REG_HIGH_LIMIT:      n_cfg.high_limit      = i_cfg_data[12:0];
                REG_MAX_DROP:        n_cfg.max_drop        = i_cfg_data[11:0];
                REG_MAX_RISE:        n_cfg.max_rise        = i_cfg_data[11:0];
                REG_ERROR_LIMIT:     n_cfg.error_limit     = i_cfg_data[7:0];
                REG_CLICK_THRESHOLD: n_cfg.click_threshold = i_cfg_data[12:0];
                default:             n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.read_interval   <= RST_READ_INTERVAL;
            r_cfg.low_limit       <= RST_LOW_LIMIT;
            r_cfg.high_limit      <= RST_HIGH_LIMIT;
            r_cfg.max_drop        <= RST_MAX_DROP;
            r_cfg.max_rise        <= RST_MAX_RISE;
            r_cfg.error_limit     <= RST_ERROR_LIMIT;
            r_cfg.click_threshold <= RST_CLICK_THRESHOLD;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

[rtl/tpf_core.sv]
// ----------------------------------------------------------------------------
// Thermocouple plausibility filter core
// Holds the filter state and evaluates one tick per advance.
// ----------------------------------------------------------------------------
`include "thermocouple_plausibility_filter_macros.svh"

module tpf_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_advance,
    input  tpf_pkg::t_item    i_item,
    input  tpf_pkg::t_cfg     i_cfg,
    output tpf_pkg::t_result  o_result
);
    import tpf_pkg::*;

    logic [15:0] r_elapsed;
    logic [11:0] r_held_temp;
    logic        r_held_valid;
    logic [7:0]  r_reject_count;
    logic        r_click_latched;

    logic [15:0] n_elapsed;
    logic [11:0] n_held_temp;
    logic        n_held_valid;
    logic [7:0]  n_reject_count;
    logic        n_click_latched;

    logic [15:0]        ticks_inc;
    logic [7:0]         count_inc;
    logic               take_sample;
    logic               sample_ok;
    logic               click;
    logic signed [13:0] reading_s;
    logic signed [13:0] delta;
    logic signed [13:0] drop_neg;
    logic signed [13:0] rise_s;
    logic signed [13:0] held_s;

    // widen everything to 14-bit signed for the compares
    assign reading_s = $signed({2'b00, i_item.reading});
    assign held_s    = $signed({2'b00, n_held_temp});
    assign delta     = reading_s - $signed({2'b00, r_held_temp});
    assign drop_neg  = -$signed({2'b00, i_cfg.max_drop});
    assign rise_s    = $signed({2'b00, i_cfg.max_rise});

    // saturating counters
    assign ticks_inc = (r_elapsed == TICKS_MAX) ? r_elapsed : r_elapsed + 16'd1;
    assign count_inc = (r_reject_count == COUNT_MAX) ? r_reject_count
                                                       : r_reject_count + 8'd1;

    assign take_sample = i_item.action || (ticks_inc >= i_cfg.read_interval);

    // plausibility: fault flag, absolute window, step from the held value
    always_comb begin
        sample_ok = !i_item.open_fault
                 && (reading_s >= $signed({i_cfg.low_limit[12], i_cfg.low_limit}))
                 && (reading_s <= $signed({i_cfg.high_limit[12], i_cfg.high_limit}));
        if (r_held_valid && ((delta < drop_neg) || (delta > rise_s))) begin
            sample_ok = 1'b0;
        end
    end

    // sample step
    always_comb begin
        n_elapsed      = take_sample ? 16'd0 : ticks_inc;
        n_held_temp    = r_held_temp;
        n_held_valid   = r_held_valid;
        n_reject_count = r_reject_count;
        if (take_sample) begin
            if (sample_ok) begin
                n_held_temp    = i_item.reading;
                n_held_valid   = 1'b1;
                n_reject_count = 8'd0;
            end else begin
                n_reject_count = count_inc;
                if (count_inc >= i_cfg.error_limit) begin
                    n_held_valid = 1'b0;
                end
            end
        end
    end

    // click latch: fire on reaching the threshold, rearm below it
    always_comb begin
        n_click_latched = r_click_latched;
        click           = 1'b0;
        if (n_held_valid) begin
            if (held_s >= $signed({i_cfg.click_threshold[12], i_cfg.click_threshold})) begin
                if (!r_click_latched) begin
                    n_click_latched = 1'b1;
                    click           = 1'b1;
                end
            end else begin
                n_click_latched = 1'b0;
            end
        end
    end

    assign o_result.sampled     = take_sample;
    assign o_result.accepted    = take_sample && sample_ok;
    assign o_result.temperature = n_held_valid ? n_held_temp : 12'd0;
    assign o_result.temp_valid  = n_held_valid;
    assign o_result.fail_count  = n_reject_count;
    assign o_result.click_event = click;

    // advance the state once per tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elapsed       <= 16'd0;
            r_held_temp     <= 12'd0;
            r_held_valid    <= 1'b0;
            r_reject_count  <= 8'd0;
            r_click_latched <= 1'b0;
        end else if (i_advance) begin
            r_elapsed       <= n_elapsed;
            r_held_temp     <= n_held_temp;
            r_held_valid    <= n_held_valid;
            r_reject_count  <= n_reject_count;
            r_click_latched <= n_click_latched;
        end
    end

    `TPF_ASSERT_NXT(a_click_latches, i_clk, i_rst_n, i_advance && click, r_click_latched)
    `TPF_ASSERT_NXT(a_accept_clears, i_clk, i_rst_n, i_advance && o_result.accepted,
                    r_held_valid && (r_reject_count == 8'd0))
    `TPF_ASSERT_NXT(a_idle_tick_counts, i_clk, i_rst_n, i_advance && !take_sample,
                    r_elapsed != 16'd0)

endmodule
